// ===== src/tcip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcip_pkg
// Shared widths, register indexes and side-band types for the triangle
// coverage interpolator.
// ----------------------------------------------------------------------------
package tcip_pkg;

	localparam int CW   = 16;                        // coordinate width
	localparam int AW   = 24;                        // attribute width
	localparam int DW   = CW + 1;                    // coordinate difference
	localparam int PW   = 2 * DW;                    // edge product
	localparam int EW   = PW + 1;                    // edge function, twice area
	localparam int WW   = EW + AW;                   // weighted attribute
	localparam int ACCW = WW + 2;                    // sum of three weights
	localparam int RW   = ACCW + 1;                  // divider remainder
	localparam int CFGW = (2 * CW > AW) ? 2 * CW : AW;
	localparam int IDXW = 3;

	localparam logic [IDXW-1:0] REG_VERTEX_A = 3'd0;
	localparam logic [IDXW-1:0] REG_VERTEX_B = 3'd1;
	localparam logic [IDXW-1:0] REG_VERTEX_C = 3'd2;
	localparam logic [IDXW-1:0] REG_ATTR_A   = 3'd3;
	localparam logic [IDXW-1:0] REG_ATTR_B   = 3'd4;
	localparam logic [IDXW-1:0] REG_ATTR_C   = 3'd5;

	typedef struct packed {
		logic covered;
		logic degenerate;
		logic neg;
	} tcip_side_t;

endpackage

// ===== src/triangle_coverage_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_coverage_interpolator
// Edge-function coverage test with top-left rule and linear attribute
// interpolation for one sample per clock when not stalled.
//
//  channel | signals                                   | direction
//  pixel   | pixel_valid, pixel_stall, pixel_x, pixel_y | in
//  result  | result_valid, result_stall, covered,      | out
//          | interpolated_value, degenerate            |
//  setup   | cfg_we, cfg_index, cfg_data               | in
//
// One word per clock unless a stall holds the stages; there are 6 front stages
// plus AW + 2 divider stages, set by the one-bit-per-stage quotient pipeline.
// Each stage moves on when the next is empty or moving, so bubbles close up.
// Reset clears valid bits and setup registers to zero; after a setup write the
// derived area is registered through ap1_q/ap2_q and then area_q.
// ----------------------------------------------------------------------------
module triangle_coverage_interpolator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcip_pkg::IDXW-1:0]        cfg_index,
	input  logic [tcip_pkg::CFGW-1:0]        cfg_data,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic signed [tcip_pkg::CW-1:0]   pixel_x,
	input  logic signed [tcip_pkg::CW-1:0]   pixel_y,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             covered,
	output logic signed [tcip_pkg::AW-1:0]   interpolated_value,
	output logic                             degenerate
);

	localparam int NF = 6;

	logic [2*tcip_pkg::CW-1:0]         vpos_q [3];
	logic signed [tcip_pkg::AW-1:0]    attr_q [3];
	logic signed [tcip_pkg::CW-1:0]    vx [3];
	logic signed [tcip_pkg::CW-1:0]    vy [3];
	logic signed [tcip_pkg::DW-1:0]    ex [3];
	logic signed [tcip_pkg::DW-1:0]    ey [3];
	logic                              tl [3];
	logic signed [tcip_pkg::PW-1:0]    ap1_q, ap2_q;
	logic signed [tcip_pkg::EW-1:0]    area_q;
	logic [tcip_pkg::EW-1:0]           dabs;

	logic [NF-1:0]                     vld_q;
	logic [NF-1:0]                     go;
	logic                              div_stall;

	logic signed [tcip_pkg::DW-1:0]    dx_s1 [3];
	logic signed [tcip_pkg::DW-1:0]    dy_s1 [3];
	logic signed [tcip_pkg::PW-1:0]    ma_s2 [3];
	logic signed [tcip_pkg::PW-1:0]    mb_s2 [3];
	logic signed [tcip_pkg::EW-1:0]    ef_s3 [3];
	logic                              cov_s3;
	logic signed [tcip_pkg::EW-1:0]    ef [3];
	logic [2:0]                        pass;
	logic signed [tcip_pkg::WW-1:0]    w_s4 [3];
	logic                              cov_s4;
	logic signed [tcip_pkg::ACCW-1:0]  acc_s5;
	logic                              cov_s5;
	logic [tcip_pkg::RW-1:0]           mag_s6;
	tcip_pkg::tcip_side_t              side_s6;

	// setup registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vpos_q[i] <= '0;
				attr_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				tcip_pkg::REG_VERTEX_A: vpos_q[0] <= cfg_data[2*tcip_pkg::CW-1:0];
				tcip_pkg::REG_VERTEX_B: vpos_q[1] <= cfg_data[2*tcip_pkg::CW-1:0];
				tcip_pkg::REG_VERTEX_C: vpos_q[2] <= cfg_data[2*tcip_pkg::CW-1:0];
				tcip_pkg::REG_ATTR_A:   attr_q[0] <= cfg_data[tcip_pkg::AW-1:0];
				tcip_pkg::REG_ATTR_B:   attr_q[1] <= cfg_data[tcip_pkg::AW-1:0];
				tcip_pkg::REG_ATTR_C:   attr_q[2] <= cfg_data[tcip_pkg::AW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i] = vpos_q[i][tcip_pkg::CW-1:0];
			vy[i] = vpos_q[i][2*tcip_pkg::CW-1:tcip_pkg::CW];
		end
		for (int i = 0; i < 3; i++) begin
			ex[i] = tcip_pkg::DW'(vx[(i+1)%3]) - tcip_pkg::DW'(vx[i]);
			ey[i] = tcip_pkg::DW'(vy[(i+1)%3]) - tcip_pkg::DW'(vy[i]);
			tl[i] = (ey[i] < 0) || (ey[i] == 0 && ex[i] > 0);
		end
	end

	// twice the signed area, two register steps behind the setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap1_q  <= '0;
			ap2_q  <= '0;
			area_q <= '0;
		end else begin
			ap1_q  <= tcip_pkg::PW'(ex[0]) * tcip_pkg::PW'(ey[1]);
			ap2_q  <= tcip_pkg::PW'(ey[0]) * tcip_pkg::PW'(ex[1]);
			area_q <= tcip_pkg::EW'(ap1_q) - tcip_pkg::EW'(ap2_q);
		end
	end
	assign dabs = area_q[tcip_pkg::EW-1] ? (~area_q + tcip_pkg::EW'(1)) : area_q;

	// stage advance chain
	assign go[NF-1] = !vld_q[NF-1] || !div_stall;
	genvar gi;
	generate
		for (gi = 0; gi < NF - 1; gi++) begin : g_go
			assign go[gi] = !vld_q[gi] || go[gi+1];
		end
	endgenerate
	assign pixel_stall = !go[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (go[0])
				vld_q[0] <= pixel_valid;
			for (int i = 1; i < NF; i++)
				if (go[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ef[i]   = tcip_pkg::EW'(ma_s2[i]) - tcip_pkg::EW'(mb_s2[i]);
			pass[i] = (ef[i] > 0) || (ef[i] == 0 && tl[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (go[0])
			for (int i = 0; i < 3; i++) begin
				dx_s1[i] <= tcip_pkg::DW'(pixel_x) - tcip_pkg::DW'(vx[i]);
				dy_s1[i] <= tcip_pkg::DW'(pixel_y) - tcip_pkg::DW'(vy[i]);
			end
		if (go[1])
			for (int i = 0; i < 3; i++) begin
				ma_s2[i] <= tcip_pkg::PW'(ex[i]) * tcip_pkg::PW'(dy_s1[i]);
				mb_s2[i] <= tcip_pkg::PW'(ey[i]) * tcip_pkg::PW'(dx_s1[i]);
			end
		if (go[2]) begin
			for (int i = 0; i < 3; i++)
				ef_s3[i] <= ef[i];
			cov_s3 <= &pass;
		end
		if (go[3]) begin
			// each vertex weighted by its opposite edge
			w_s4[0] <= tcip_pkg::WW'(ef_s3[1]) * tcip_pkg::WW'(attr_q[0]);
			w_s4[1] <= tcip_pkg::WW'(ef_s3[2]) * tcip_pkg::WW'(attr_q[1]);
			w_s4[2] <= tcip_pkg::WW'(ef_s3[0]) * tcip_pkg::WW'(attr_q[2]);
			cov_s4  <= cov_s3;
		end
		if (go[4]) begin
			acc_s5 <= tcip_pkg::ACCW'(w_s4[0]) + tcip_pkg::ACCW'(w_s4[1])
				+ tcip_pkg::ACCW'(w_s4[2]);
			cov_s5 <= cov_s4;
		end
		if (go[5]) begin
			mag_s6 <= acc_s5[tcip_pkg::ACCW-1]
				? (~tcip_pkg::RW'(acc_s5) + tcip_pkg::RW'(1)) : tcip_pkg::RW'(acc_s5);
			side_s6.covered    <= cov_s5;
			side_s6.degenerate <= (area_q == 0);
			side_s6.neg        <= acc_s5[tcip_pkg::ACCW-1] ^ area_q[tcip_pkg::EW-1];
		end
	end

	tcip_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vld_q[NF-1]),
		.in_stall   (div_stall),
		.mag        (mag_s6),
		.side       (side_s6),
		.divisor    (dabs),
		.out_valid  (result_valid),
		.out_stall  (result_stall),
		.covered    (covered),
		.value      (interpolated_value),
		.degenerate (degenerate)
	);

endmodule

// ===== src/tcip_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcip_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detect, sign restore and saturation to a signed attribute value.
// ----------------------------------------------------------------------------
module tcip_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [tcip_pkg::RW-1:0] mag,
	input  tcip_pkg::tcip_side_t   side,
	input  logic [tcip_pkg::EW-1:0] divisor,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   covered,
	output logic signed [tcip_pkg::AW-1:0] value,
	output logic                   degenerate
);

	localparam int NS = tcip_pkg::AW + 2;

	logic [NS-1:0]                vld_q;
	logic [NS-1:0]                go;
	logic [tcip_pkg::RW-1:0]      rem_s  [NS-1];
	logic [tcip_pkg::AW-1:0]      quo_s  [NS-1];
	logic                         ovf_s  [NS-1];
	tcip_pkg::tcip_side_t         side_s [NS-1];
	logic [tcip_pkg::RW-1:0]      dlim;
	logic [tcip_pkg::AW-1:0]      mag_q;
	logic                         sat_pos;
	logic                         sat_neg;
	logic signed [tcip_pkg::AW-1:0] res;
	localparam logic [tcip_pkg::AW-1:0] HI = {1'b0, {(tcip_pkg::AW-1){1'b1}}};
	localparam logic [tcip_pkg::AW-1:0] LO = {1'b1, {(tcip_pkg::AW-1){1'b0}}};

	assign go[NS-1] = !vld_q[NS-1] || !out_stall;
	genvar gi;
	generate
		for (gi = 0; gi < NS - 1; gi++) begin : g_go
			assign go[gi] = !vld_q[gi] || go[gi+1];
		end
	endgenerate
	assign in_stall  = !go[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (go[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < NS; i++)
				if (go[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// quotient too large for the attribute width: saturate later
	assign dlim = tcip_pkg::RW'(divisor) << tcip_pkg::AW;

	always_ff @(posedge clk) begin
		if (go[0]) begin
			rem_s[0]  <= mag;
			quo_s[0]  <= '0;
			ovf_s[0]  <= (mag >= dlim);
			side_s[0] <= side;
		end
	end

	generate
		for (gi = 1; gi < NS - 1; gi++) begin : g_bit
			localparam int B = tcip_pkg::AW - gi;
			logic [tcip_pkg::RW-1:0] sh;
			assign sh = tcip_pkg::RW'(divisor) << B;
			always_ff @(posedge clk) begin
				if (go[gi]) begin
					ovf_s[gi]  <= ovf_s[gi-1];
					side_s[gi] <= side_s[gi-1];
					if (rem_s[gi-1] >= sh) begin
						rem_s[gi] <= rem_s[gi-1] - sh;
						quo_s[gi] <= quo_s[gi-1] | (tcip_pkg::AW'(1) << B);
					end else begin
						rem_s[gi] <= rem_s[gi-1];
						quo_s[gi] <= quo_s[gi-1];
					end
				end
			end
		end
	endgenerate

	assign mag_q   = quo_s[NS-2];
	assign sat_pos = ovf_s[NS-2] || mag_q[tcip_pkg::AW-1];
	assign sat_neg = ovf_s[NS-2] || (mag_q > LO);

	always_comb begin
		if (side_s[NS-2].degenerate)
			res = '0;
		else if (side_s[NS-2].neg)
			res = sat_neg ? LO : (~mag_q + tcip_pkg::AW'(1));
		else
			res = sat_pos ? HI : mag_q;
	end

	always_ff @(posedge clk) begin
		if (go[NS-1]) begin
			covered    <= side_s[NS-2].covered;
			degenerate <= side_s[NS-2].degenerate;
			value      <= res;
		end
	end

endmodule
